### rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Depends on nothing; imported by the top level and its checker.
`default_nettype none

package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_DEL_SHIFT,
    S_SEARCH,
    S_FINISH,
    S_REPLY
  } state_t;

endpackage

`default_nettype wire

### rtl/ple_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; no package needed.
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data when no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/positional_list_engine.sv
// Positional list engine: ordered list of signed words with insert, delete and search.
// Depends on ple_pkg and ple_ram.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | sink      | in_valid / in_stall | opcode, position, value
//   out     | source    | out_valid/out_stall | found_position, removed_value, status,
//           |           |                     | length, last
//
// One item at a time; in_stall is low only while idle. A decode state comes first, then
// the entry RAM (one read, one write per cycle) sets the pace: insert and delete shift
// the entries from the position on (none for an append), search reads every entry, and
// a final state hands over the result.
// Search results leave one per match; each waits for the next match or the search end.
// Reset is synchronous and empties the list; the RAM contents are not cleared.
// A stalled output holds its beat and pauses search at the next match.
`default_nettype none

module positional_list_engine
  import ple_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [6:0]  position,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       found_position,
  output logic [31:0]      removed_value,
  output logic [1:0]       status,
  output logic [6:0]       length,
  output logic             last
);

  state_t state, state_next;

  op_t              op_q;
  logic [6:0]       pos_q;
  logic [31:0]      val_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic             pend;
  logic             grab;
  logic [IDX_W-1:0] wr_addr;
  logic             cmp_vld;
  logic [CNT_W-1:0] cmp_pos;
  logic             hit_valid;
  logic [CNT_W-1:0] hit_pos;
  logic [1:0]       res_status;
  logic [31:0]      res_removed;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;

  logic             emit, emit_last;
  logic [6:0]       emit_pos;
  logic [31:0]      emit_removed;
  logic [1:0]       emit_status;

  logic             out_free;
  logic [7:0]       pos8, cnt8;
  logic             ins_bad, del_bad, full;
  logic [CNT_W-1:0] pos_c;
  logic [IDX_W-1:0] pos_idx;
  logic             ins_more, del_more, srch_more;
  logic             match, srch_adv;

  ple_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign pos8      = {1'b0, pos_q};
  assign cnt8      = 8'(count);
  assign ins_bad   = (pos8 == 8'd0) || (pos8 > cnt8 + 8'd1);
  assign del_bad   = (pos8 == 8'd0) || (pos8 > cnt8);
  assign full      = (count == CNT_W'(CAPACITY));
  assign pos_c     = CNT_W'(pos_q);
  assign pos_idx   = IDX_W'(pos_q - 7'd1);
  assign ins_more  = (idx >= pos_c);
  assign del_more  = (idx < count);
  assign srch_more = (idx < count);
  assign match     = (ram_rdata == val_q);
  // a second match cannot leave while the previous one is still queued
  assign srch_adv  = !(cmp_vld && match && hit_valid && !out_free);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (op_q)
          OP_INSERT: state_next = (ins_bad || full) ? S_REPLY : S_INS_SHIFT;
          OP_DELETE: state_next = del_bad ? S_REPLY : S_DEL_SHIFT;
          OP_SEARCH: state_next = S_SEARCH;
          default:   state_next = S_REPLY;
        endcase
      end
      S_INS_SHIFT: begin
        if (!ins_more && !pend) state_next = S_REPLY;
      end
      S_DEL_SHIFT: begin
        if (!del_more && !pend) state_next = S_REPLY;
      end
      S_SEARCH: begin
        if (!srch_more && !cmp_vld) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      S_REPLY: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = wr_addr;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = IDX_W'(idx);
    emit         = 1'b0;
    emit_pos     = 7'd0;
    emit_removed = 32'd0;
    emit_status  = ST_OK;
    emit_last    = 1'b1;
    case (state)
      S_INS_SHIFT: begin
        // move entry idx-1 up to idx, one read and one write per cycle
        if (ins_more) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(idx - CNT_W'(1));
        end
        if (pend) begin
          ram_we = 1'b1;
        end else if (!ins_more) begin
          ram_we    = 1'b1;
          ram_waddr = pos_idx;
          ram_wdata = val_q;
        end
      end
      S_DEL_SHIFT: begin
        if (del_more) begin
          ram_re = 1'b1;
        end
        if (pend && !grab) begin
          ram_we = 1'b1;
        end
      end
      S_SEARCH: begin
        if (srch_adv && srch_more) begin
          ram_re = 1'b1;
        end
        if (cmp_vld && match && hit_valid && out_free) begin
          emit      = 1'b1;
          emit_pos  = 7'(hit_pos);
          emit_last = 1'b0;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          emit = 1'b1;
          if (hit_valid) begin
            emit_pos = 7'(hit_pos);
          end else begin
            emit_status = ST_NOTFOUND;
          end
        end
      end
      S_REPLY: begin
        if (out_free) begin
          emit         = 1'b1;
          emit_removed = res_removed;
          emit_status  = res_status;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      grab      <= 1'b0;
      cmp_vld   <= 1'b0;
      hit_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_DECODE: begin
          pend      <= 1'b0;
          grab      <= 1'b0;
          cmp_vld   <= 1'b0;
          hit_valid <= 1'b0;
        end
        S_INS_SHIFT: begin
          pend <= ins_more;
          if (!ins_more && !pend) count <= count + CNT_W'(1);
        end
        S_DEL_SHIFT: begin
          pend <= del_more;
          if (del_more) grab <= (idx == pos_c - CNT_W'(1));
          if (!del_more && !pend) count <= count - CNT_W'(1);
        end
        S_SEARCH: begin
          if (srch_adv) begin
            cmp_vld <= srch_more;
            if (cmp_vld && match) hit_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q  <= op_t'(opcode);
      pos_q <= position;
      val_q <= value;
    end

    if (emit) begin
      found_position <= emit_pos;
      removed_value  <= emit_removed;
      status         <= emit_status;
      length         <= 7'(count);
      last           <= emit_last;
    end

    case (state)
      S_DECODE: begin
        res_removed <= 32'd0;
        case (op_q)
          OP_INSERT: begin
            res_status <= ins_bad ? ST_BADPOS : (full ? ST_FULL : ST_OK);
            idx        <= count;
          end
          OP_DELETE: begin
            res_status <= del_bad ? ST_BADPOS : ST_OK;
            idx        <= pos_c - CNT_W'(1);
          end
          default: begin
            res_status <= ST_OK;
            idx        <= '0;
          end
        endcase
      end
      S_INS_SHIFT: begin
        if (ins_more) begin
          idx     <= idx - CNT_W'(1);
          wr_addr <= IDX_W'(idx);
        end
      end
      S_DEL_SHIFT: begin
        if (del_more) begin
          idx     <= idx + CNT_W'(1);
          wr_addr <= IDX_W'(idx - CNT_W'(1));
        end
        // first read of a delete is the removed entry
        if (pend && grab) res_removed <= ram_rdata;
      end
      S_SEARCH: begin
        if (srch_adv) begin
          if (srch_more) begin
            idx     <= idx + CNT_W'(1);
            cmp_pos <= idx + CNT_W'(1);
          end
          if (cmp_vld && match) hit_pos <= cmp_pos;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/ple_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg.
`default_nettype none

module ple_port_checks
  import ple_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  opcode,
  input wire logic [6:0]  position,
  input wire logic [31:0] value,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [6:0]  found_position,
  input wire logic [31:0] removed_value,
  input wire logic [1:0]  status,
  input wire logic [6:0]  length,
  input wire logic        last
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found_position) &&
      $stable(removed_value) && $stable(status) && $stable(length) && $stable(last))
    else $error("stalled result beat changed");

  // an accepted item keeps the block busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after an accept");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last && found_position == 7'd0 &&
      removed_value == 32'd0)
    else $error("error result is not a lone final beat");

  a_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_position != 7'd0 |-> status == ST_OK && removed_value == 32'd0 &&
      found_position <= length)
    else $error("match beat inconsistent");

endmodule

bind positional_list_engine ple_port_checks u_checker (.*);

`default_nettype wire
